FILE: design/ffra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_pkg: shared types and constants of the first-fit region allocator
// Holds the beat layout, the action and status codes, and the command and
// status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package ffra_pkg;

	// Default depth of the region table.
	localparam int DEF_MAX_REGIONS = 64;

	// Address and field widths.
	localparam int ADDR_W  = 64;
	localparam int ALIGN_W = 32;

	// Beat layout on both channels.
	localparam int S_TDATA_W = 224;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 128;
	localparam int M_TUSER_W = 2;

	// Action codes carried in the low bits of s_tuser.
	typedef logic [1:0] action_t;
	localparam action_t ACT_LOAD    = 2'd0;
	localparam action_t ACT_ALLOC   = 2'd1;
	localparam action_t ACT_ALIGNED = 2'd2;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_FIT    = 2'd1,
		ST_BAD_ALIGN = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    capture;
		logic    prep;
		logic    load_wr;
		logic    scan_step;
		logic    hit;
		logic    carve;
		logic    res_set;
		status_t res_code;
		logic    out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		action_t action;
		logic    is_free;
		logic    full;
		logic    bad_align;
		logic    ovf;
		logic    more;
		logic    pend;
		logic    fit;
		logic    out_free;
	} dp_stat_t;

endpackage

FILE: design/ffra_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module ffra_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: design/ffra_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_dp: datapath of the first-fit region allocator
// Holds the captured item, the region table memory, the scan pointer, the
// carve arithmetic and the output register.
// ----------------------------------------------------------------------------
module ffra_dp #(
	parameter int MAX_REGIONS = ffra_pkg::DEF_MAX_REGIONS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [ffra_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic [ffra_pkg::S_TUSER_W-1:0]   s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ffra_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic [ffra_pkg::M_TUSER_W-1:0]   m_tuser,
	input  ffra_pkg::dp_cmd_t                cmd,
	output ffra_pkg::dp_stat_t               st
);
	import ffra_pkg::*;

	localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CW = $clog2(MAX_REGIONS + 1);
	localparam int EW = 2 * ADDR_W;

	// Captured item.
	action_t             action_q;
	logic                is_free_q;
	logic [ADDR_W-1:0]   base_q;
	logic [ADDR_W-1:0]   len_q;
	logic [ADDR_W-1:0]   req_q;
	logic [ALIGN_W-1:0]  align_q;

	// Prepared request.
	logic [ADDR_W-1:0]   req_eff_q;
	logic [ALIGN_W:0]    a7_q;
	logic [ADDR_W-1:0]   mask_q;
	logic                aligned_q;

	// Table and scan state.
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       idx_q;
	logic                pend_q;
	logic [AW-1:0]       chk_q;
	logic [ADDR_W-1:0]   hit_base_q;
	logic [ADDR_W-1:0]   hit_len_q;
	logic [AW-1:0]       hit_idx_q;

	// Result and output registers.
	status_t             res_status_q;
	logic [ADDR_W-1:0]   res_grant_q;
	logic [ADDR_W-1:0]   res_raw_q;
	logic                out_valid_q;
	status_t             out_status_q;
	logic [ADDR_W-1:0]   out_grant_q;
	logic [ADDR_W-1:0]   out_raw_q;

	// Combinational values.
	logic [ALIGN_W-1:0]  a8;
	logic [ALIGN_W-1:0]  a8m1;
	logic [ALIGN_W:0]    a7;
	logic [ADDR_W:0]     total;
	logic [ADDR_W-1:0]   ld_base;
	logic [ADDR_W-1:0]   ld_len;
	logic [EW-1:0]       rd_data;
	logic [ADDR_W-1:0]   rd_base;
	logic [ADDR_W-1:0]   rd_len;
	logic                more;
	logic                fit;
	logic [ADDR_W-1:0]   grant;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [EW-1:0]       ram_wdata;
	logic                ram_re;

	// Capture the item on its input beat.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q  <= s_tuser[1:0];
			is_free_q <= s_tuser[2];
			base_q    <= s_tdata[63:0];
			len_q     <= s_tdata[127:64];
			req_q     <= s_tdata[191:128];
			align_q   <= s_tdata[223:192];
		end
	end

	// Alignment: raise to 8, check power of two, and size the reservation.
	always_comb begin
		a8    = (align_q < ALIGN_W'(8)) ? ALIGN_W'(8) : align_q;
		a8m1  = a8 - ALIGN_W'(1);
		a7    = {1'b0, a8} + (ALIGN_W + 1)'(7);
		total = {1'b0, req_q} + {{(ADDR_W - ALIGN_W){1'b0}}, a7};
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			req_eff_q <= (action_q == ACT_ALIGNED) ? total[ADDR_W-1:0] : req_q;
			a7_q      <= a7;
			mask_q    <= ~{{(ADDR_W - ALIGN_W){1'b0}}, a8m1};
			aligned_q <= (action_q == ACT_ALIGNED);
		end
	end

	// A load at base zero moves up by one byte; the length saturates at zero.
	always_comb begin
		ld_base = base_q;
		ld_len  = len_q;
		if (base_q == '0) begin
			ld_base = ADDR_W'(1);
			if (len_q != '0) begin
				ld_len = len_q - ADDR_W'(1);
			end
		end
	end

	// Region count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.load_wr) begin
			count_q <= count_q + CW'(1);
		end
	end

	// Scan pointer: issue one read per step, check it on the next cycle.
	assign more = (idx_q < count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			pend_q <= 1'b0;
		end else if (cmd.prep) begin
			idx_q  <= '0;
			pend_q <= 1'b0;
		end else if (cmd.scan_step) begin
			if (more) begin
				idx_q <= idx_q + CW'(1);
			end
			pend_q <= more;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			chk_q <= idx_q[AW-1:0];
		end
	end

	// Fit test on the entry just read: long enough and no address wrap.
	assign rd_base = rd_data[ADDR_W-1:0];
	assign rd_len  = rd_data[EW-1:ADDR_W];
	assign fit     = (rd_len >= req_eff_q) && (rd_base <= ~req_eff_q);

	always_ff @(posedge clk) begin
		if (cmd.hit) begin
			hit_base_q <= rd_base;
			hit_len_q  <= rd_len;
			hit_idx_q  <= chk_q;
		end
	end

	// Table memory: loads append, carves update the hit entry.
	always_comb begin
		ram_we    = cmd.load_wr || cmd.carve;
		ram_re    = cmd.scan_step && more;
		ram_waddr = hit_idx_q;
		ram_wdata = {hit_len_q - req_eff_q, hit_base_q + req_eff_q};
		if (cmd.load_wr) begin
			ram_waddr = count_q[AW-1:0];
			ram_wdata = {ld_len, ld_base};
		end
	end

	ffra_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_REGIONS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_data)
	);

	// Returned address, rounded up for aligned requests.
	assign grant = aligned_q ?
		((hit_base_q + {{(ADDR_W - ALIGN_W - 1){1'b0}}, a7_q}) & mask_q) : hit_base_q;

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			res_status_q <= cmd.res_code;
			res_grant_q  <= '0;
			res_raw_q    <= '0;
		end else if (cmd.carve) begin
			res_status_q <= ST_OK;
			res_grant_q  <= grant;
			res_raw_q    <= hit_base_q;
		end
	end

	// Output register; holds the beat until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_grant_q  <= res_grant_q;
			out_raw_q    <= res_raw_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_raw_q, out_grant_q};
	assign m_tuser  = out_status_q;

	// Status toward the controller.
	always_comb begin
		st.action    = action_q;
		st.is_free   = is_free_q;
		st.full      = (count_q >= CW'(MAX_REGIONS));
		st.bad_align = ((a8 & a8m1) != '0);
		st.ovf       = total[ADDR_W];
		st.more      = more;
		st.pend      = pend_q;
		st.fit       = fit;
		st.out_free  = !out_valid_q || m_tready;
	end

endmodule

FILE: design/ffra_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_ctrl: controller of the first-fit region allocator
// Sequences capture, request preparation, the table scan, the carve and the
// hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module ffra_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output ffra_pkg::dp_cmd_t   cmd,
	input  ffra_pkg::dp_stat_t  st
);
	import ffra_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_PREP  = 5'b00010,
		S_SCAN  = 5'b00100,
		S_CARVE = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and datapath commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				priority if (st.action == ACT_LOAD) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = (st.is_free && st.full) ? ST_FULL : ST_OK;
					cmd.load_wr  = st.is_free && !st.full;
					state_d      = S_RESP;
				end else if (st.action == ACT_ALLOC) begin
					state_d = S_SCAN;
				end else if (st.action == ACT_ALIGNED) begin
					if (st.bad_align) begin
						cmd.res_set  = 1'b1;
						cmd.res_code = ST_BAD_ALIGN;
						state_d      = S_RESP;
					end else if (st.ovf) begin
						cmd.res_set  = 1'b1;
						cmd.res_code = ST_NO_FIT;
						state_d      = S_RESP;
					end else begin
						state_d = S_SCAN;
					end
				end else begin
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_OK;
					state_d      = S_RESP;
				end
			end
			S_SCAN: begin
				if (st.pend && st.fit) begin
					cmd.hit = 1'b1;
					state_d = S_CARVE;
				end else if (!st.pend && !st.more) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_NO_FIT;
					state_d      = S_RESP;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_CARVE: begin
				cmd.carve = 1'b1;
				state_d   = S_RESP;
			end
			S_RESP: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: design/first_fit_region_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_region_allocator: first-fit allocator over a table of regions
// Usage:
//   Input beats on s_* carry one item. s_tuser holds the action (load region,
//   allocate, aligned allocate) and the free flag; s_tdata holds the region
//   base and length, the request size and the alignment.
//   Every input beat produces exactly one output beat on m_*: m_tuser holds
//   the status, m_tdata the granted and the raw address.
//   A load, an undefined action or a rejected request passes from the capture
//   through S_PREP and S_RESP into the output register. An allocation reads
//   one region per cycle in S_SCAN through the single read port of the table
//   memory and, when a region fits, carves it in S_CARVE before S_RESP.
//   The block takes one item at a time; s_tready is high only while the
//   block waits for an item.
//   A finished result sits in the output register while the next item is
//   taken; if the receiver stalls, that next result waits inside the block
//   and no further item is accepted until the output register frees up.
//   Reset empties the table (region count zero) and drops any pending beat.
// ----------------------------------------------------------------------------
module first_fit_region_allocator #(
	parameter int MAX_REGIONS = ffra_pkg::DEF_MAX_REGIONS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// region_base, region_length, request_bytes, align_bytes
	input  logic [ffra_pkg::S_TDATA_W-1:0]  s_tdata,
	// action, region_is_free
	input  logic [ffra_pkg::S_TUSER_W-1:0]  s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// grant_address, raw_address
	output logic [ffra_pkg::M_TDATA_W-1:0]  m_tdata,
	// status
	output logic [ffra_pkg::M_TUSER_W-1:0]  m_tuser
);
	import ffra_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t st;

	// Controller.
	ffra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.st       (st)
	);

	// Datapath.
	ffra_dp #(
		.MAX_REGIONS(MAX_REGIONS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.st       (st)
	);

	// An accepted item keeps the input closed on the next cycle.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while an item is in progress");

	// The output register is loaded only when it is free or being emptied.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("output beat overwritten before it was taken");

	// Failed results carry zero addresses.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata == '0))
		else $error("failed result with nonzero address");

	// A carve only follows a table hit.
	a_carve_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.carve |-> $past(cmd.hit))
		else $error("carve without a preceding hit");

endmodule
